FILE: hw/rtl/aob_pkg.sv
package aob_pkg;

  localparam int NumCh    = 4;
  localparam int ChW      = 8;
  localparam int CoordW   = 12;
  localparam int CfgW     = 13;
  localparam int ChCntW   = 3;
  localparam int MaxSide  = 4096;
  localparam int NumRegs  = 6;
  localparam int RegIdxW  = $clog2(NumRegs);
  localparam int AddrW    = RegIdxW + 2;
  localparam int DataW    = 32;
  localparam int NumLanes = NumCh - 1;
  localparam int ProdW    = 2 * ChW;
  localparam int NumW     = 3 * ChW;
  localparam int QuoW     = ChW;
  localparam int DivFirst = 3;
  localparam int NumStg   = DivFirst + QuoW;
  localparam int ChFull   = 255;
  localparam int CopyMin  = 253;
  localparam int ZeroMax  = 2;

  typedef logic [NumCh-1:0][ChW-1:0] pix_t;

  typedef enum logic [RegIdxW-1:0] {
    RegSrcCh = RegIdxW'(0),
    RegDstCh = RegIdxW'(1),
    RegOffX  = RegIdxW'(2),
    RegOffY  = RegIdxW'(3),
    RegDstW  = RegIdxW'(4),
    RegDstH  = RegIdxW'(5)
  } reg_idx_e;

  typedef struct packed {
    logic [CoordW-1:0] src_x;
    logic [CoordW-1:0] src_y;
    logic [ChW-1:0]    src_c0;
    logic [ChW-1:0]    src_c1;
    logic [ChW-1:0]    src_c2;
    logic [ChW-1:0]    src_c3;
    logic [ChW-1:0]    dst_c0;
    logic [ChW-1:0]    dst_c1;
    logic [ChW-1:0]    dst_c2;
    logic [ChW-1:0]    dst_c3;
  } in_t;

  typedef struct packed {
    logic              write_enable;
    logic [CoordW-1:0] dst_x;
    logic [CoordW-1:0] dst_y;
    logic [ChW-1:0]    out_c0;
    logic [ChW-1:0]    out_c1;
    logic [ChW-1:0]    out_c2;
    logic [ChW-1:0]    out_c3;
  } out_t;

  typedef struct packed {
    logic [ChCntW-1:0]      sc;
    logic [ChCntW-1:0]      dc;
    logic signed [CfgW-1:0] off_x;
    logic signed [CfgW-1:0] off_y;
    logic [CfgW-1:0]        w;
    logic [CfgW-1:0]        h;
  } cfg_t;

  typedef struct packed {
    logic              in_bounds;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              copy;
    logic              zero;
    logic [ChW-1:0]    oa;
    pix_t              sv;
  } side_t;

  function automatic logic [ChCntW-1:0] eff_ch(input logic [ChCntW-1:0] v);
    logic [ChCntW-1:0] r;
    if (v == '0) begin
      r = ChCntW'(1);
    end else if (v > ChCntW'(NumCh)) begin
      r = ChCntW'(NumCh);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CfgW-1:0] cap_side(input logic [CfgW-1:0] v);
    logic [CfgW-1:0] r;
    if (int'(v) > MaxSide) begin
      r = CfgW'(MaxSide);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/aob_in_if.sv
interface aob_in_if;
  import aob_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/aob_out_if.sv
interface aob_out_if;
  import aob_pkg::*;

  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/aob_cfg.sv
module aob_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aob_pkg::AddrW-1:0]  paddr,
  input  logic [aob_pkg::DataW-1:0]  pwdata,
  output logic [aob_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output aob_pkg::cfg_t              cfg_o
);
  import aob_pkg::*;

  logic [ChCntW-1:0] src_ch_q, dst_ch_q;
  logic [CfgW-1:0]   off_x_q, off_y_q, dst_w_q, dst_h_q;
  reg_idx_e          idx;
  logic              wr;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_ch_q <= ChCntW'(NumCh);
      dst_ch_q <= ChCntW'(NumCh);
      off_x_q  <= '0;
      off_y_q  <= '0;
      dst_w_q  <= '0;
      dst_h_q  <= '0;
    end else if (wr) begin
      case (idx)
        RegSrcCh: src_ch_q <= pwdata[ChCntW-1:0];
        RegDstCh: dst_ch_q <= pwdata[ChCntW-1:0];
        RegOffX:  off_x_q  <= pwdata[CfgW-1:0];
        RegOffY:  off_y_q  <= pwdata[CfgW-1:0];
        RegDstW:  dst_w_q  <= pwdata[CfgW-1:0];
        RegDstH:  dst_h_q  <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegSrcCh: prdata = DataW'(src_ch_q);
      RegDstCh: prdata = DataW'(dst_ch_q);
      RegOffX:  prdata = DataW'(off_x_q);
      RegOffY:  prdata = DataW'(off_y_q);
      RegDstW:  prdata = DataW'(dst_w_q);
      RegDstH:  prdata = DataW'(dst_h_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.sc    = eff_ch(src_ch_q);
  assign cfg_o.dc    = eff_ch(dst_ch_q);
  assign cfg_o.off_x = $signed(off_x_q);
  assign cfg_o.off_y = $signed(off_y_q);
  assign cfg_o.w     = cap_side(dst_w_q);
  assign cfg_o.h     = cap_side(dst_h_q);

endmodule

FILE: hw/rtl/aob_front.sv
module aob_front (
  input  logic                          clk_i,
  input  logic [aob_pkg::NumStg-1:0]    en_i,
  input  aob_pkg::in_t                  in_i,
  input  aob_pkg::cfg_t                 cfg_i,
  output aob_pkg::pix_t                 sv_o,
  output aob_pkg::pix_t                 d_o,
  output logic [aob_pkg::ChW-1:0]       sa_o,
  output logic [aob_pkg::ChW-1:0]       da_o,
  output logic [aob_pkg::ProdW-1:0]     q_o,
  output aob_pkg::side_t                side_o
);
  import aob_pkg::*;

  in_t                   in_q;
  logic signed [CfgW:0]  px, py;
  logic                  in_bounds, gray;
  pix_t                  s, sv;
  logic [ChW-1:0]        sa, da;
  logic [ProdW-1:0]      sa255_q, dab_q, q, oa_sum;
  logic [ProdW-1:0]      q_q;
  side_t                 side_q [1:NumStg-1];
  side_t                 side2;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      in_q <= in_i;
    end
  end

  assign px = $signed({{(CfgW+1-CoordW){1'b0}}, in_q.src_x})
            + $signed({cfg_i.off_x[CfgW-1], cfg_i.off_x});
  assign py = $signed({{(CfgW+1-CoordW){1'b0}}, in_q.src_y})
            + $signed({cfg_i.off_y[CfgW-1], cfg_i.off_y});
  assign in_bounds = !px[CfgW] && (px[CfgW-1:0] < cfg_i.w)
                  && !py[CfgW] && (py[CfgW-1:0] < cfg_i.h);

  assign s   = {in_q.src_c3, in_q.src_c2, in_q.src_c1, in_q.src_c0};
  assign d_o = {in_q.dst_c3, in_q.dst_c2, in_q.dst_c1, in_q.dst_c0};
  assign gray = cfg_i.sc < cfg_i.dc;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      sv[c] = gray ? s[0] : s[c];
    end
  end

  assign sa   = (cfg_i.sc < ChCntW'(NumCh)) ? ChW'(ChFull) : s[NumCh-1];
  assign da   = (cfg_i.dc < ChCntW'(NumCh)) ? ChW'(ChFull) : d_o[NumCh-1];
  assign sv_o = sv;
  assign sa_o = sa;
  assign da_o = da;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sa255_q             <= {sa, {ChW{1'b0}}} - ProdW'(sa);
      dab_q               <= ProdW'(da) * ProdW'(ChW'(ChFull) - sa);
      side_q[1].in_bounds <= in_bounds;
      side_q[1].x         <= px[CoordW-1:0];
      side_q[1].y         <= py[CoordW-1:0];
      side_q[1].copy      <= (sa >= ChW'(CopyMin)) && (da >= ChW'(CopyMin));
      side_q[1].zero      <= 1'b0;
      side_q[1].oa        <= '0;
      side_q[1].sv        <= sv;
    end
  end

  assign q      = sa255_q + dab_q;
  assign oa_sum = q + ProdW'(q[ProdW-1:ChW]) + ProdW'(1);

  always_comb begin
    side2      = side_q[1];
    side2.oa   = oa_sum[ProdW-1:ChW];
    side2.zero = oa_sum[ProdW-1:ChW] <= ChW'(ZeroMax);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      q_q       <= q;
      side_q[2] <= side2;
    end
  end

  for (genvar k = 3; k < NumStg; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign q_o    = q_q;
  assign side_o = side_q[NumStg-1];

endmodule

FILE: hw/rtl/aob_lane.sv
module aob_lane (
  input  logic                        clk_i,
  input  logic [aob_pkg::NumStg-1:1]  en_i,
  input  logic [aob_pkg::ChW-1:0]     sv_i,
  input  logic [aob_pkg::ChW-1:0]     d_i,
  input  logic [aob_pkg::ChW-1:0]     sa_i,
  input  logic [aob_pkg::ChW-1:0]     da_i,
  input  logic [aob_pkg::ProdW-1:0]   q_i,
  output logic [aob_pkg::QuoW-1:0]    quo_o
);
  import aob_pkg::*;

  logic [ProdW-1:0] svsa_q, dda_q;
  logic [ChW-1:0]   nsa_q;
  logic [NumW-1:0]  n_q;
  logic [NumW-1:0]  rem_q [QuoW-1];
  logic [ProdW-1:0] dq_q  [QuoW-1];
  logic [QuoW-1:0]  quo_q [QuoW];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      svsa_q <= ProdW'(sv_i) * ProdW'(sa_i);
      dda_q  <= ProdW'(d_i) * ProdW'(da_i);
      nsa_q  <= ChW'(ChFull) - sa_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      n_q <= ({svsa_q, {ChW{1'b0}}} - NumW'(svsa_q)) + NumW'(dda_q) * NumW'(nsa_q);
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [NumW-1:0]  rem_in;
    logic [ProdW-1:0] dq_in;
    logic [QuoW-1:0]  quo_in;
    logic [NumW:0]    diff;

    if (k == 0) begin : g_first
      assign rem_in = n_q;
      assign dq_in  = q_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign diff = {1'b0, rem_in} - {1'b0, NumW'(dq_in) << (QuoW-1-k)};

    always_ff @(posedge clk_i) begin
      if (en_i[DivFirst+k]) begin
        quo_q[k] <= diff[NumW] ? quo_in : (quo_in | (QuoW'(1) << (QuoW-1-k)));
      end
    end

    if (k < QuoW-1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[DivFirst+k]) begin
          rem_q[k] <= diff[NumW] ? rem_in : diff[NumW-1:0];
          dq_q[k]  <= dq_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule

FILE: hw/rtl/aob_merge.sv
module aob_merge (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  logic                                        ready_i,
  input  aob_pkg::side_t                              side_i,
  input  logic [aob_pkg::NumLanes-1:0][aob_pkg::ChW-1:0] quo_i,
  input  logic [aob_pkg::ChCntW-1:0]                  dc_i,
  output logic                                        en_o,
  output logic                                        valid_o,
  output aob_pkg::out_t                               data_o
);
  import aob_pkg::*;

  logic valid_q;
  out_t data_q, data_d;
  pix_t ch;

  assign en_o = !valid_q || ready_i;

  always_comb begin
    for (int c = 0; c < NumCh; c++) begin
      if (!side_i.in_bounds || ChCntW'(c) >= dc_i) begin
        ch[c] = '0;
      end else if (side_i.copy) begin
        ch[c] = side_i.sv[c];
      end else if (side_i.zero) begin
        ch[c] = '0;
      end else if (c == NumCh-1) begin
        ch[c] = side_i.oa;
      end else begin
        ch[c] = quo_i[c];
      end
    end
    data_d.write_enable = side_i.in_bounds;
    data_d.dst_x        = side_i.in_bounds ? side_i.x : '0;
    data_d.dst_y        = side_i.in_bounds ? side_i.y : '0;
    data_d.out_c0       = ch[0];
    data_d.out_c1       = ch[1];
    data_d.out_c2       = ch[2];
    data_d.out_c3       = ch[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

FILE: hw/rtl/alpha_over_blend_clipped.sv
// Throughput: one pixel per cycle while the output is not stalled; each color
// lane runs an 8-stage restoring divider, one quotient bit per stage, and each
// stage holds only while it is full and the stage after it holds.
// Reset clears the pipeline valid bits and sets the registers to four source
// and four destination channels, zero offsets and a zero destination size.
module alpha_over_blend_clipped (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aob_pkg::AddrW-1:0]  paddr,
  input  logic [aob_pkg::DataW-1:0]  pwdata,
  output logic [aob_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  aob_in_if.sink                     pix_i,
  aob_out_if.source                  pix_o
);
  import aob_pkg::*;

  cfg_t                            cfg;
  logic [NumStg-1:0]               v_q;
  logic [NumStg:0]                 en;
  pix_t                            sv, d;
  logic [ChW-1:0]                  sa, da;
  logic [ProdW-1:0]                q;
  side_t                           side;
  logic [NumLanes-1:0][ChW-1:0]    quo;

  aob_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  for (genvar s = 0; s < NumStg; s++) begin : g_en
    assign en[s] = !v_q[s] || en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NumStg; s++) begin
        if (en[s]) begin
          v_q[s] <= (s == 0) ? pix_i.valid : v_q[s-1];
        end
      end
    end
  end

  assign pix_i.ready = en[0];

  aob_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[NumStg-1:0]),
    .in_i   (pix_i.data),
    .cfg_i  (cfg),
    .sv_o   (sv),
    .d_o    (d),
    .sa_o   (sa),
    .da_o   (da),
    .q_o    (q),
    .side_o (side)
  );

  for (genvar c = 0; c < NumLanes; c++) begin : g_lane
    aob_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en[NumStg-1:1]),
      .sv_i  (sv[c]),
      .d_i   (d[c]),
      .sa_i  (sa),
      .da_i  (da),
      .q_i   (q),
      .quo_o (quo[c])
    );
  end

  aob_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_q[NumStg-1]),
    .ready_i (pix_o.ready),
    .side_i  (side),
    .quo_i   (quo),
    .dc_i    (cfg.dc),
    .en_o    (en[NumStg]),
    .valid_o (pix_o.valid),
    .data_o  (pix_o.data)
  );

endmodule

FILE: hw/rtl/aob_checker.sv
module aob_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input aob_pkg::out_t out_data_i
);
  import aob_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.write_enable |->
      out_data_i.dst_x == '0 && out_data_i.dst_y == '0 &&
      out_data_i.out_c0 == '0 && out_data_i.out_c1 == '0 &&
      out_data_i.out_c2 == '0 && out_data_i.out_c3 == '0)
    else $error("clipped result carries nonzero fields");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i && in_ready_i)
    else $error("pipeline not empty after reset");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |=> !out_valid_i)
    else $error("result appeared before any transfer could reach the output");

endmodule

bind alpha_over_blend_clipped aob_checker u_aob_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready),
  .out_data_i  (pix_o.data)
);

FILE: tb/sv/alpha_over_blend_clipped_test.sv
module alpha_over_blend_clipped_test;
  import aob_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int ItemsPerPhase = 125;
  localparam int NumPhases = 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  aob_in_if pix_in ();
  aob_out_if pix_out ();

  alpha_over_blend_clipped dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_i   (pix_in),
    .pix_o   (pix_out)
  );

  logic [ChCntW-1:0] cfg_sc = ChCntW'(4);
  logic [ChCntW-1:0] cfg_dc = ChCntW'(4);
  logic signed [CfgW-1:0] cfg_ox = '0;
  logic signed [CfgW-1:0] cfg_oy = '0;
  logic [CfgW-1:0] cfg_w = '0;
  logic [CfgW-1:0] cfg_h = '0;

  in_t pixels_to_send[$];
  out_t blended_pixels[$];
  int unsigned src_idle_pct;
  int unsigned dst_idle_pct;
  int mismatches = 0;
  int cycle_count = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("alpha_over_blend_clipped_test failed");
      $finish;
    end
  end

  function automatic int clamp_channels(logic [ChCntW-1:0] v);
    if (v == '0) return 1;
    if (v > ChCntW'(NumCh)) return NumCh;
    return int'(v);
  endfunction

  function automatic int clamp_side(logic [CfgW-1:0] v);
    if (int'(v) > MaxSide) return MaxSide;
    return int'(v);
  endfunction

  function automatic out_t composite_pixel(in_t p);
    int sc, dc, ox, oy, px, py, sa, da, q, oa, n, v, c;
    int s[4], d[4], sv[4], res[4];
    logic gray;
    out_t r;
    r = '0;
    sc = clamp_channels(cfg_sc);
    dc = clamp_channels(cfg_dc);
    ox = cfg_ox;
    oy = cfg_oy;
    px = int'(p.src_x) + ox;
    py = int'(p.src_y) + oy;
    if (px < 0 || px >= clamp_side(cfg_w) || py < 0 || py >= clamp_side(cfg_h)) return r;
    r.write_enable = 1'b1;
    r.dst_x = px[CoordW-1:0];
    r.dst_y = py[CoordW-1:0];
    s = '{int'(p.src_c0), int'(p.src_c1), int'(p.src_c2), int'(p.src_c3)};
    d = '{int'(p.dst_c0), int'(p.dst_c1), int'(p.dst_c2), int'(p.dst_c3)};
    gray = sc < dc;
    for (c = 0; c < NumCh; c++) begin
      sv[c] = gray ? s[0] : s[c];
      res[c] = 0;
    end
    sa = (sc < NumCh) ? ChFull : s[3];
    da = (dc < NumCh) ? ChFull : d[3];
    if (sa >= CopyMin && da >= CopyMin) begin
      for (c = 0; c < dc; c++) res[c] = sv[c];
    end else begin
      q = sa * ChFull + da * (ChFull - sa);
      oa = q / ChFull;
      if (oa > ZeroMax) begin
        for (c = 0; c < dc; c++) begin
          n = sv[c] * sa * ChFull + d[c] * da * (ChFull - sa);
          v = n / q;
          res[c] = (v > ChFull) ? ChFull : v;
        end
        if (dc == NumCh) res[3] = (oa > ChFull) ? ChFull : oa;
      end
    end
    r.out_c0 = res[0][ChW-1:0];
    r.out_c1 = res[1][ChW-1:0];
    r.out_c2 = res[2][ChW-1:0];
    r.out_c3 = res[3][ChW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch, %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Driver: hold the item until its transfer, then advance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_in.valid <= 1'b0;
      pix_in.data <= '0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        blended_pixels.push_back(composite_pixel(pix_in.data));
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          pix_in.valid <= 1'b1;
          pix_in.data <= pixels_to_send.pop_front();
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else begin
      pix_out.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (blended_pixels.size() == 0) begin
        report_mismatch("result transfer with nothing pending");
      end else begin
        want = blended_pixels.pop_front();
        check_field("write_enable", pix_out.data.write_enable, want.write_enable);
        check_field("dst_x", pix_out.data.dst_x, want.dst_x);
        check_field("dst_y", pix_out.data.dst_y, want.dst_y);
        check_field("out_c0", pix_out.data.out_c0, want.out_c0);
        check_field("out_c1", pix_out.data.out_c1, want.out_c1);
        check_field("out_c2", pix_out.data.out_c2, want.out_c2);
        check_field("out_c3", pix_out.data.out_c3, want.out_c3);
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [DataW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegSrcCh: cfg_sc = value[ChCntW-1:0];
      RegDstCh: cfg_dc = value[ChCntW-1:0];
      RegOffX:  cfg_ox = value[CfgW-1:0];
      RegOffY:  cfg_oy = value[CfgW-1:0];
      RegDstW:  cfg_w = value[CfgW-1:0];
      RegDstH:  cfg_h = value[CfgW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int sc, int dc, int ox, int oy, int w, int h);
    write_reg(RegSrcCh, sc);
    write_reg(RegDstCh, dc);
    write_reg(RegOffX, ox);
    write_reg(RegOffY, oy);
    write_reg(RegDstW, w);
    write_reg(RegDstH, h);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pixels_to_send.size() != 0 || pix_in.valid || blended_pixels.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic add_pixel(int x, int y, int s0, int s1, int s2, int s3,
                           int d0, int d1, int d2, int d3);
    in_t p;
    p.src_x = x[CoordW-1:0];
    p.src_y = y[CoordW-1:0];
    p.src_c0 = s0[ChW-1:0];
    p.src_c1 = s1[ChW-1:0];
    p.src_c2 = s2[ChW-1:0];
    p.src_c3 = s3[ChW-1:0];
    p.dst_c0 = d0[ChW-1:0];
    p.dst_c1 = d1[ChW-1:0];
    p.dst_c2 = d2[ChW-1:0];
    p.dst_c3 = d3[ChW-1:0];
    pixels_to_send.push_back(p);
  endtask

  function automatic int pick_channels();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 7);
    return $urandom_range(1, 4);
  endfunction

  function automatic int pick_offset();
    int r;
    case ($urandom_range(0, 5))
      0: r = -4096;
      1: r = 4095;
      2: r = int'($urandom_range(0, 8191)) - 4096;
      3: r = 0;
      default: r = int'($urandom_range(0, 512)) - 256;
    endcase
    return r;
  endfunction

  function automatic int pick_side();
    int r;
    case ($urandom_range(0, 5))
      0: r = MaxSide;
      1: r = $urandom_range(MaxSide + 1, 8191);
      2: r = $urandom_range(1, 16);
      default: r = $urandom_range(1, MaxSide);
    endcase
    return r;
  endfunction

  // Aim most coordinates inside the destination, with some just past its edges.
  function automatic int pick_coord(int off, int side);
    int t;
    if (side == 0 || $urandom_range(0, 7) == 0) return $urandom_range(0, 4095);
    if ($urandom_range(0, 9) == 0) begin
      t = $urandom_range(0, 1) ? -1 : side;
    end else begin
      t = $urandom_range(0, side - 1);
    end
    t = t - off;
    if (t < 0 || t > 4095) return $urandom_range(0, 4095);
    return t;
  endfunction

  function automatic int pick_level();
    int r;
    case ($urandom_range(0, 5))
      0: r = 0;
      1: r = 255;
      2: r = $urandom_range(0, 3);
      3: r = $urandom_range(252, 255);
      default: r = $urandom_range(0, 255);
    endcase
    return r;
  endfunction

  initial begin
    int phase;
    int k;
    src_idle_pct = 28;
    dst_idle_pct = 83;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset size is zero: everything lands outside.
    add_pixel(0, 0, 10, 20, 30, 40, 50, 60, 70, 80);
    add_pixel(4095, 4095, 255, 255, 255, 255, 255, 255, 255, 255);
    wait_drained();

    set_config(4, 4, 0, 0, MaxSide, MaxSide);
    add_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_pixel(4095, 4095, 255, 255, 255, 255, 255, 255, 255, 255);
    add_pixel(17, 4095, 11, 22, 33, 253, 44, 55, 66, 253);
    add_pixel(4095, 3, 11, 22, 33, 252, 44, 55, 66, 255);
    add_pixel(5, 6, 200, 100, 50, 1, 90, 80, 70, 2);
    add_pixel(7, 8, 200, 100, 50, 2, 90, 80, 70, 2);
    add_pixel(9, 10, 200, 100, 50, 128, 90, 80, 70, 64);
    add_pixel(11, 12, 255, 0, 255, 0, 1, 254, 3, 255);
    wait_drained();

    // Gray source: channel 0 stands for all source color channels and the source alpha is full.
    set_config(1, 4, 4095, 0, 8191, 8191);
    add_pixel(0, 100, 77, 1, 2, 3, 10, 20, 30, 255);
    add_pixel(0, 4095, 77, 1, 2, 100, 10, 20, 30, 100);
    add_pixel(1, 0, 77, 1, 2, 3, 10, 20, 30, 255);
    wait_drained();

    set_config(7, 0, -4096, 4095, 1, 1);
    add_pixel(4095, 0, 1, 2, 3, 4, 5, 6, 7, 8);
    add_pixel(0, 4095, 1, 2, 3, 4, 5, 6, 7, 8);
    wait_drained();

    set_config(2, 3, -5, 3, 100, 50);
    add_pixel(5, 46, 150, 9, 9, 9, 20, 30, 40, 50);
    add_pixel(104, 0, 150, 9, 9, 9, 20, 30, 40, 50);
    add_pixel(105, 0, 150, 9, 9, 9, 20, 30, 40, 50);
    add_pixel(4, 0, 150, 9, 9, 9, 20, 30, 40, 50);
    add_pixel(50, 47, 150, 9, 9, 9, 20, 30, 40, 50);
    wait_drained();

    set_config(4, 3, 0, 0, 64, 64);
    add_pixel(1, 1, 200, 100, 50, 100, 10, 20, 30, 0);
    add_pixel(63, 63, 200, 100, 50, 255, 10, 20, 30, 0);
    add_pixel(2, 2, 200, 100, 50, 0, 10, 20, 30, 0);

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      if (phase < 3) begin
        src_idle_pct = 28;
        dst_idle_pct = 83;
      end else if (phase < 6) begin
        src_idle_pct = 83;
        dst_idle_pct = 28;
      end else begin
        src_idle_pct = 0;
        dst_idle_pct = 0;
      end
      set_config(pick_channels(), pick_channels(), pick_offset(), pick_offset(),
                 pick_side(), pick_side());
      for (k = 0; k < ItemsPerPhase; k++) begin
        add_pixel(pick_coord(cfg_ox, clamp_side(cfg_w)), pick_coord(cfg_oy, clamp_side(cfg_h)),
                  pick_level(), pick_level(), pick_level(), pick_level(),
                  pick_level(), pick_level(), pick_level(), pick_level());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("alpha_over_blend_clipped_test passed");
    end else begin
      $display("alpha_over_blend_clipped_test failed");
    end
    $finish;
  end

endmodule

FILE: alpha_over_blend_clipped.f
hw/rtl/aob_pkg.sv
hw/rtl/aob_in_if.sv
hw/rtl/aob_out_if.sv
hw/rtl/aob_cfg.sv
hw/rtl/aob_front.sv
hw/rtl/aob_lane.sv
hw/rtl/aob_merge.sv
hw/rtl/alpha_over_blend_clipped.sv
hw/rtl/aob_checker.sv
tb/sv/alpha_over_blend_clipped_test.sv
